// File: hw/rtl/pair_bistable_force_macros.svh
// ----------------------------------------------------------------------------
// pair_bistable_force_macros
// assertion helpers used by pbf_checker
// ----------------------------------------------------------------------------
`ifndef PAIR_BISTABLE_FORCE_MACROS_SVH
`define PAIR_BISTABLE_FORCE_MACROS_SVH

// concurrent check, quiet while reset is held
`define PBF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs during reset
`define PBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// types, widths and saturation helpers for the double-well pair force unit
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int NUM_TYPES = 16;
    localparam int TYPE_W    = 4;
    localparam int POS_W     = 32;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SUM_W     = 2 * POS_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int SQRT_LAT  = SUM_W / 2;
    localparam int DIV_N_W   = 65;
    localparam int DIV_D_W   = 34;
    localparam int DIV_LAT   = DIV_N_W;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int MASK_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WELL_OFFSET  = 3'd0,
        CFG_WELL_RADIUS  = 3'd1,
        CFG_ENERGY_SCALE = 3'd2,
        CFG_TYPE_MASK    = 3'd3,
        CFG_FILTER_EN    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_INACTIVE   = 2'd0,
        ST_COMPUTED   = 2'd1,
        ST_COINCIDENT = 2'd2
    } t_status;

    // everything that rides along with a pair through the pipeline
    typedef struct packed {
        logic                    active;
        logic [2:0][DIFF_W-1:0]  d;
        logic [ROOT_W-1:0]       r;
        logic signed [31:0]      arg;
        logic signed [31:0]      u;
        logic signed [31:0]      w;
        logic signed [31:0]      q;
        logic signed [63:0]      sw;
        logic signed [31:0]      g;
        logic signed [31:0]      energy;
        logic signed [31:0]      s;
    } t_work;

    typedef struct packed {
        logic signed [31:0] energy;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        t_status            pair_status;
    } t_result;

    // signed quotient from magnitude and sign, clamped to 32 bits
    function automatic logic signed [31:0] sat_quot(input logic [DIV_N_W-1:0] mag,
                                                   input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            if (mag > DIV_N_W'(64'h8000_0000)) res = 32'sh8000_0000;
            else res = $signed(32'(32'd0 - mag[31:0]));
        end else begin
            if (mag > DIV_N_W'(64'h7fff_ffff)) res = 32'sh7fff_ffff;
            else res = $signed(mag[31:0]);
        end
        return res;
    endfunction

    // floor(v / 2^16) clamped to 32 bits
    function automatic logic signed [31:0] sat_shr16(input logic signed [63:0] v);
        logic signed [63:0] sh;
        logic signed [31:0] res;
        sh = v >>> 16;
        if (sh > 64'sd2147483647) res = 32'sh7fff_ffff;
        else if (sh < -64'sd2147483648) res = 32'sh8000_0000;
        else res = $signed(sh[31:0]);
        return res;
    endfunction

    // 4 * p clamped to 32 bits
    function automatic logic signed [31:0] sat_x4(input logic signed [31:0] p);
        logic signed [31:0] res;
        if (p > 32'sd536870911) res = 32'sh7fff_ffff;
        else if (p < -32'sd536870912) res = 32'sh8000_0000;
        else res = $signed({p[29:0], 2'b00});
        return res;
    endfunction

endpackage

// File: hw/rtl/pbf_in_if.sv
// ----------------------------------------------------------------------------
// pbf_in_if
// pair channel: two positions and two type indices per beat
// ----------------------------------------------------------------------------
interface pbf_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [pbf_pkg::POS_W-1:0]  first_x;
    logic signed [pbf_pkg::POS_W-1:0]  first_y;
    logic signed [pbf_pkg::POS_W-1:0]  first_z;
    logic signed [pbf_pkg::POS_W-1:0]  second_x;
    logic signed [pbf_pkg::POS_W-1:0]  second_y;
    logic signed [pbf_pkg::POS_W-1:0]  second_z;
    logic [pbf_pkg::TYPE_W-1:0]        first_type;
    logic [pbf_pkg::TYPE_W-1:0]        second_type;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, first_type, second_type, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, first_type, second_type, output ready);
endinterface

// File: hw/rtl/pbf_out_if.sv
// ----------------------------------------------------------------------------
// pbf_out_if
// result channel: energy, force on the first particle and status per beat
// ----------------------------------------------------------------------------
interface pbf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] energy;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         pair_status;

    modport source (output valid, energy, force_x, force_y, force_z, pair_status,
                    input ready);
    modport sink (input valid, energy, force_x, force_y, force_z, pair_status,
                  output ready);
endinterface

// File: hw/rtl/pbf_div.sv
// ----------------------------------------------------------------------------
// pbf_div
// pipelined restoring unsigned divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module pbf_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [pbf_pkg::DIV_N_W-1:0]  i_num,
    input  logic [pbf_pkg::DIV_D_W-1:0]  i_den,
    output logic [pbf_pkg::DIV_N_W-1:0]  o_quot
);
    localparam int NW = pbf_pkg::DIV_N_W;
    localparam int DW = pbf_pkg::DIV_D_W;
    localparam int LAT = pbf_pkg::DIV_LAT;

    // acc holds the dividend bits not yet used, quotient bits shift in below
    logic [DW-1:0] r_rem [LAT];
    logic [NW-1:0] r_acc [LAT];
    logic [DW-1:0] r_den [LAT];
    logic [DW-1:0] n_rem [LAT];
    logic [NW-1:0] n_acc [LAT];

    for (genvar k = 0; k < LAT; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] acc_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign acc_in = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign acc_in = r_acc[k-1];
            assign den_in = r_den[k-1];
        end

        always_comb begin
            trial = {rem_in, acc_in[NW-1]};
            ge = trial >= {1'b0, den_in};
            n_rem[k] = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
            n_acc[k] = {acc_in[NW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[k];
                r_acc[k] <= n_acc[k];
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quot = r_acc[LAT-1];
endmodule

// File: hw/rtl/pbf_sqrt.sv
// ----------------------------------------------------------------------------
// pbf_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module pbf_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pbf_pkg::SUM_W-1:0]   i_rad,
    output logic [pbf_pkg::ROOT_W-1:0]  o_root
);
    localparam int SW  = pbf_pkg::SUM_W;
    localparam int RW  = pbf_pkg::ROOT_W;
    localparam int MW  = RW + 3;
    localparam int LAT = pbf_pkg::SQRT_LAT;

    logic [MW-1:0] r_rem  [LAT];
    logic [RW-1:0] r_root [LAT];
    logic [SW-1:0] r_rad  [LAT];
    logic [MW-1:0] n_rem  [LAT];
    logic [RW-1:0] n_root [LAT];

    for (genvar k = 0; k < LAT; k++) begin : g_stage
        logic [MW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] rad_in;
        logic [MW-1:0] cur;
        logic [MW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        always_comb begin
            // remainder stays below twice the root, so its top bits are free
            cur = {rem_in[MW-3:0], rad_in[SW-1 -: 2]};
            trial = MW'({root_in, 2'b01});
            ge = cur >= trial;
            n_rem[k] = ge ? cur - trial : cur;
            n_root[k] = {root_in[RW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= {rad_in[SW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[LAT-1];
endmodule

// File: hw/rtl/pair_bistable_force.sv
// ----------------------------------------------------------------------------
// pair_bistable_force
// double-well pair potential and force on the first particle, Q16.16
// ----------------------------------------------------------------------------
// Takes one pair per clock while the skid register is empty and returns one
// result per pair, in order. The pipeline is built from bit-serial units: a
// 33-stage square root for |d| and three 65-stage restoring dividers in a row
// (by the radius for the well argument, by the radius for the force gain, and
// by r for each force lane), plus sixteen arithmetic stages and the output
// register. A result that waits at the output is held in a skid register
// while new pairs still enter; the pipeline freezes only when the skid
// register is full. Configuration is written through a plain write port and
// is read directly by the pipeline, so the user must change it only while no
// pair is in flight; the block itself does not enforce this.
module pair_bistable_force (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pbf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pbf_pkg::CFG_W-1:0]     i_cfg_data,
    pbf_in_if.sink                        i_pair,
    pbf_out_if.source                     o_res
);
    localparam int SQL = pbf_pkg::SQRT_LAT;
    localparam int DL  = pbf_pkg::DIV_LAT;
    localparam int NW  = pbf_pkg::DIV_N_W;
    localparam int DW  = pbf_pkg::DIV_D_W;

    // configuration
    logic [pbf_pkg::CFG_W-1:0]  r_well_offset;
    logic [pbf_pkg::CFG_W-1:0]  r_well_radius;
    logic [pbf_pkg::CFG_W-1:0]  r_energy_scale;
    logic [pbf_pkg::MASK_W-1:0] r_type_mask;
    logic                       r_filter_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_well_offset  <= pbf_pkg::CFG_W'(65536);
            r_well_radius  <= pbf_pkg::CFG_W'(65536);
            r_energy_scale <= pbf_pkg::CFG_W'(65536);
            r_type_mask    <= '0;
            r_filter_en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (pbf_pkg::t_cfg_idx'(i_cfg_idx))
                pbf_pkg::CFG_WELL_OFFSET:  r_well_offset  <= i_cfg_data;
                pbf_pkg::CFG_WELL_RADIUS:  r_well_radius  <= i_cfg_data;
                pbf_pkg::CFG_ENERGY_SCALE: r_energy_scale <= i_cfg_data;
                pbf_pkg::CFG_TYPE_MASK:    r_type_mask    <= i_cfg_data[pbf_pkg::MASK_W-1:0];
                pbf_pkg::CFG_FILTER_EN:    r_filter_en    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic [pbf_pkg::CFG_W-1:0] w_rad;
    assign w_rad = (r_well_radius == '0) ? pbf_pkg::CFG_W'(1) : r_well_radius;

    logic w_en;
    logic r_skid_v;
    assign w_en = !r_skid_v;
    assign i_pair.ready = w_en;

    // stage a: differences and type filter
    pbf_pkg::t_work r_a, n_a;
    logic           r_a_v;

    always_comb begin
        logic t1_ok, t2_ok;
        t1_ok = (32'(i_pair.first_type) < pbf_pkg::NUM_TYPES) &&
                r_type_mask[i_pair.first_type];
        t2_ok = (32'(i_pair.second_type) < pbf_pkg::NUM_TYPES) &&
                r_type_mask[i_pair.second_type];
        n_a = '0;
        n_a.active = !r_filter_en || (t1_ok && t2_ok);
        n_a.d[0] = {i_pair.first_x[31], i_pair.first_x} - {i_pair.second_x[31], i_pair.second_x};
        n_a.d[1] = {i_pair.first_y[31], i_pair.first_y} - {i_pair.second_y[31], i_pair.second_y};
        n_a.d[2] = {i_pair.first_z[31], i_pair.first_z} - {i_pair.second_z[31], i_pair.second_z};
    end

    // stage b: squares of the magnitudes
    pbf_pkg::t_work r_b;
    logic [63:0]    r_b_sq [3];
    logic [63:0]    n_b_sq [3];
    logic           r_b_v;

    always_comb begin
        logic [pbf_pkg::DIFF_W-1:0] mag;
        for (int i = 0; i < 3; i++) begin
            mag = r_a.d[i][pbf_pkg::DIFF_W-1] ? pbf_pkg::DIFF_W'(0 - r_a.d[i]) : r_a.d[i];
            n_b_sq[i] = mag[31:0] * mag[31:0];
        end
    end

    // stage c: squared length
    pbf_pkg::t_work             r_c;
    logic [pbf_pkg::SUM_W-1:0]  r_c_sum;
    logic                       r_c_v;

    // square root, work rides alongside
    logic [pbf_pkg::ROOT_W-1:0] w_root;
    pbf_pkg::t_work             r_sd [SQL];
    logic                       r_sd_v [SQL];

    pbf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_c_sum),
        .o_root (w_root)
    );

    // stage d: distance from the well centre, dividend for the argument
    pbf_pkg::t_work r_d, n_d;
    logic [NW-1:0]  r_d_num, n_d_num;
    logic           r_d_neg, n_d_neg;
    logic           r_d_v;

    always_comb begin
        logic signed [34:0] t;
        logic [34:0]        tmag;
        n_d = r_sd[SQL-1];
        n_d.r = w_root;
        t = $signed({2'b00, w_root}) - $signed({4'b0000, r_well_offset}) -
            $signed({4'b0000, w_rad});
        tmag = t[34] ? 35'(0 - t) : t;
        n_d_neg = t[34];
        n_d_num = NW'({tmag, 16'h0000});
    end

    logic [NW-1:0]  w_q1;
    pbf_pkg::t_work r_d1 [DL];
    logic           r_d1_v [DL];

    pbf_div u_div_arg (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_d_num),
        .i_den  (DW'(w_rad)),
        .o_quot (w_q1)
    );

    logic r_d1_neg [DL];

    // stage e: argument
    pbf_pkg::t_work r_e, n_e;
    logic           r_e_v;

    always_comb begin
        n_e = r_d1[DL-1];
        n_e.arg = pbf_pkg::sat_quot(w_q1, r_d1_neg[DL-1]);
    end

    // stage f: arg squared
    pbf_pkg::t_work     r_f;
    logic signed [63:0] r_f_aa;
    logic               r_f_v;

    // stage g: u = 1 - arg^2
    pbf_pkg::t_work r_g, n_g;
    logic           r_g_v;

    always_comb begin
        n_g = r_f;
        n_g.u = 32'sd65536 - pbf_pkg::sat_shr16(r_f_aa);
    end

    // stage h: u^2 and u*arg
    pbf_pkg::t_work     r_h;
    logic signed [63:0] r_h_uu, r_h_ua;
    logic               r_h_v;

    // stage i: w and q
    pbf_pkg::t_work r_i, n_i;
    logic           r_i_v;

    always_comb begin
        n_i = r_h;
        n_i.w = pbf_pkg::sat_shr16(r_h_uu);
        n_i.q = pbf_pkg::sat_x4(pbf_pkg::sat_shr16(r_h_ua));
    end

    // stage j: scale*w, dividend for the force gain
    pbf_pkg::t_work r_j, n_j;
    logic [NW-1:0]  r_j_num, n_j_num;
    logic           r_j_neg, n_j_neg;
    logic           r_j_v;

    always_comb begin
        logic [31:0] qmag;
        n_j = r_i;
        n_j.sw = $signed({1'b0, r_energy_scale}) * r_i.w;
        qmag = r_i.q[31] ? 32'(32'd0 - r_i.q) : r_i.q;
        n_j_neg = r_i.q[31];
        n_j_num = NW'({qmag, 16'h0000});
    end

    logic [NW-1:0]  w_q2;
    pbf_pkg::t_work r_d2 [DL];
    logic           r_d2_v [DL];
    logic           r_d2_neg [DL];

    pbf_div u_div_gain (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_j_num),
        .i_den  (DW'(w_rad)),
        .o_quot (w_q2)
    );

    // stage k: gain and energy
    pbf_pkg::t_work r_k, n_k;
    logic           r_k_v;

    always_comb begin
        n_k = r_d2[DL-1];
        n_k.g = pbf_pkg::sat_quot(w_q2, r_d2_neg[DL-1]);
        n_k.energy = pbf_pkg::sat_shr16(r_d2[DL-1].sw);
    end

    // stage l: g*scale
    pbf_pkg::t_work     r_l;
    logic signed [63:0] r_l_gs;
    logic               r_l_v;

    // stage m: s
    pbf_pkg::t_work r_m, n_m;
    logic           r_m_v;

    always_comb begin
        n_m = r_l;
        n_m.s = pbf_pkg::sat_shr16(r_l_gs);
    end

    // stage n: s*d per lane
    pbf_pkg::t_work     r_n;
    logic signed [64:0] r_n_sd [3];
    logic signed [64:0] n_n_sd [3];
    logic               r_n_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_n_sd[i] = r_m.s * $signed(r_m.d[i]);
        end
    end

    // stage o: force dividends
    pbf_pkg::t_work r_o;
    logic [NW-1:0]  r_o_num [3];
    logic [NW-1:0]  n_o_num [3];
    logic           r_o_neg [3];
    logic           r_o_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_o_num[i] = r_n_sd[i][64] ? NW'(0 - r_n_sd[i]) : NW'(r_n_sd[i]);
        end
    end

    logic [NW-1:0]  w_fq [3];
    pbf_pkg::t_work r_d3 [DL];
    logic           r_d3_v [DL];
    logic [2:0]     r_d3_neg [DL];

    for (genvar i = 0; i < 3; i++) begin : g_fdiv
        pbf_div u_div_force (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_o_num[i]),
            .i_den  (DW'(r_o.r)),
            .o_quot (w_fq[i])
        );
    end

    // stage p: assemble result
    pbf_pkg::t_result r_p, n_p;
    logic             r_p_v;

    always_comb begin
        pbf_pkg::t_work wk;
        wk = r_d3[DL-1];
        n_p = '0;
        if (!wk.active) begin
            n_p.pair_status = pbf_pkg::ST_INACTIVE;
        end else if (wk.r == '0) begin
            n_p.energy = wk.energy;
            n_p.pair_status = pbf_pkg::ST_COINCIDENT;
        end else begin
            n_p.energy  = wk.energy;
            n_p.force_x = pbf_pkg::sat_quot(w_fq[0], r_d3_neg[DL-1][0]);
            n_p.force_y = pbf_pkg::sat_quot(w_fq[1], r_d3_neg[DL-1][1]);
            n_p.force_z = pbf_pkg::sat_quot(w_fq[2], r_d3_neg[DL-1][2]);
            n_p.pair_status = pbf_pkg::ST_COMPUTED;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= n_a;
            r_b <= r_a;
            for (int i = 0; i < 3; i++) r_b_sq[i] <= n_b_sq[i];
            r_c <= r_b;
            r_c_sum <= pbf_pkg::SUM_W'(r_b_sq[0]) + pbf_pkg::SUM_W'(r_b_sq[1]) +
                       pbf_pkg::SUM_W'(r_b_sq[2]);
            r_sd[0] <= r_c;
            for (int k = 1; k < SQL; k++) r_sd[k] <= r_sd[k-1];
            r_d <= n_d;
            r_d_num <= n_d_num;
            r_d_neg <= n_d_neg;
            r_d1[0] <= r_d;
            r_d1_neg[0] <= r_d_neg;
            for (int k = 1; k < DL; k++) begin
                r_d1[k] <= r_d1[k-1];
                r_d1_neg[k] <= r_d1_neg[k-1];
            end
            r_e <= n_e;
            r_f <= r_e;
            r_f_aa <= r_e.arg * r_e.arg;
            r_g <= n_g;
            r_h <= r_g;
            r_h_uu <= r_g.u * r_g.u;
            r_h_ua <= r_g.u * r_g.arg;
            r_i <= n_i;
            r_j <= n_j;
            r_j_num <= n_j_num;
            r_j_neg <= n_j_neg;
            r_d2[0] <= r_j;
            r_d2_neg[0] <= r_j_neg;
            for (int k = 1; k < DL; k++) begin
                r_d2[k] <= r_d2[k-1];
                r_d2_neg[k] <= r_d2_neg[k-1];
            end
            r_k <= n_k;
            r_l <= r_k;
            r_l_gs <= r_k.g * $signed({1'b0, r_energy_scale});
            r_m <= n_m;
            r_n <= r_m;
            for (int i = 0; i < 3; i++) r_n_sd[i] <= n_n_sd[i];
            r_o <= r_n;
            for (int i = 0; i < 3; i++) begin
                r_o_num[i] <= n_o_num[i];
                r_o_neg[i] <= r_n_sd[i][64];
            end
            r_d3[0] <= r_o;
            r_d3_neg[0] <= {r_o_neg[2], r_o_neg[1], r_o_neg[0]};
            for (int k = 1; k < DL; k++) begin
                r_d3[k] <= r_d3[k-1];
                r_d3_neg[k] <= r_d3_neg[k-1];
            end
            r_p <= n_p;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            for (int k = 0; k < SQL; k++) r_sd_v[k] <= 1'b0;
            r_d_v <= 1'b0;
            for (int k = 0; k < DL; k++) begin
                r_d1_v[k] <= 1'b0;
                r_d2_v[k] <= 1'b0;
                r_d3_v[k] <= 1'b0;
            end
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
            r_l_v <= 1'b0;
            r_m_v <= 1'b0;
            r_n_v <= 1'b0;
            r_o_v <= 1'b0;
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_pair.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_sd_v[0] <= r_c_v;
            for (int k = 1; k < SQL; k++) r_sd_v[k] <= r_sd_v[k-1];
            r_d_v <= r_sd_v[SQL-1];
            r_d1_v[0] <= r_d_v;
            for (int k = 1; k < DL; k++) r_d1_v[k] <= r_d1_v[k-1];
            r_e_v <= r_d1_v[DL-1];
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
            r_d2_v[0] <= r_j_v;
            for (int k = 1; k < DL; k++) r_d2_v[k] <= r_d2_v[k-1];
            r_k_v <= r_d2_v[DL-1];
            r_l_v <= r_k_v;
            r_m_v <= r_l_v;
            r_n_v <= r_m_v;
            r_o_v <= r_n_v;
            r_d3_v[0] <= r_o_v;
            for (int k = 1; k < DL; k++) r_d3_v[k] <= r_d3_v[k-1];
            r_p_v <= r_d3_v[DL-1];
        end
    end

    // output register with skid
    pbf_pkg::t_result r_out, r_skid;
    logic             r_out_v;
    logic             w_take;

    assign w_take = r_out_v && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_p_v) begin
            if (!r_out_v || w_take) begin
                r_out   <= r_p;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= r_p;
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.energy      = r_out.energy;
    assign o_res.force_x     = r_out.force_x;
    assign o_res.force_y     = r_out.force_y;
    assign o_res.force_z     = r_out.force_z;
    assign o_res.pair_status = r_out.pair_status;
endmodule

// File: hw/rtl/pbf_checker.sv
// ----------------------------------------------------------------------------
// pbf_checker
// port-level checks on the pair force unit, bound to the top level
// ----------------------------------------------------------------------------
`include "pair_bistable_force_macros.svh"

module pbf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_energy,
    input logic signed [31:0] i_force_x,
    input logic signed [31:0] i_force_y,
    input logic signed [31:0] i_force_z,
    input logic [1:0]         i_status
);
    // a stalled beat stays on the port
    `PBF_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped while stalled")

    // a filtered pair carries no energy and no force
    `PBF_ASSERT(a_inactive_zero, i_clk, i_rst_n, i_out_valid && i_status == pbf_pkg::ST_INACTIVE |-> i_energy == 0 && i_force_x == 0 && i_force_y == 0 && i_force_z == 0, "inactive pair with nonzero output")

    // coincident positions give no force
    `PBF_ASSERT(a_coincident_zero, i_clk, i_rst_n, i_out_valid && i_status == pbf_pkg::ST_COINCIDENT |-> i_force_x == 0 && i_force_y == 0 && i_force_z == 0, "coincident pair with nonzero force")

    // reset empties the output and skid registers
    `PBF_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready, "output not cleared by reset")
endmodule

bind pair_bistable_force pbf_checker u_pbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_energy    (o_res.energy),
    .i_force_x   (o_res.force_x),
    .i_force_y   (o_res.force_y),
    .i_force_z   (o_res.force_z),
    .i_status    (o_res.pair_status)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the double-well pair force unit: pairs are driven
// through the input channel, each accepted pair is scored by an in-bench
// fixed-point model, and every result beat is compared in order against it
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [pbf_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = pbf_pkg::CFG_IDX_W'(5);
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 600;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic [3:0]         ta, tb;
    } t_pair;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [pbf_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [pbf_pkg::CFG_W-1:0]     i_cfg_data;

    pbf_in_if  pair_ch ();
    pbf_out_if res_ch ();

    pair_bistable_force DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pair     (pair_ch.sink),
        .o_res      (res_ch.source)
    );

    // register copies used by the model
    longint well_x0, well_rad, e_scale;
    logic [15:0] type_mask;
    logic filt_on;

    pbf_pkg::t_result expected_results[$];
    int n_pairs, n_results, n_errors, n_inactive, n_coincident;
    int cycles;
    bit idling;
    int hold_len;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_results.size());
            $display("** pair_bistable_force: FAILED **");
            $finish;
        end
    end

    function automatic longint sat32(t_wide v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return longint'(v);
    endfunction

    function automatic pbf_pkg::t_result force_of_pair(t_pair p);
        pbf_pkg::t_result res;
        longint d[3], fo[3], r, rad, t, arg, sq, u, w, pq, q, g, s;
        logic [33:0] mag;
        logic [67:0] sum, c;
        logic [33:0] root;
        t_wide prod;
        res = '0;
        if (filt_on && !(type_mask[p.ta] && type_mask[p.tb] &&
                         p.ta < pbf_pkg::NUM_TYPES && p.tb < pbf_pkg::NUM_TYPES)) begin
            res.pair_status = pbf_pkg::ST_INACTIVE;
            return res;
        end
        d[0] = longint'(p.ax) - longint'(p.bx);
        d[1] = longint'(p.ay) - longint'(p.by);
        d[2] = longint'(p.az) - longint'(p.bz);
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag = d[i] < 0 ? 34'(-d[i]) : 34'(d[i]);
            sum = sum + 68'(mag) * 68'(mag);
        end
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            c = 68'(root | (34'd1 << b));
            if (c * c <= sum) root = c[33:0];
        end
        r = longint'(root);
        rad = well_rad == 0 ? 1 : well_rad;
        t = r - well_x0 - rad;
        arg = sat32((t * 65536) / rad);
        sq = sat32((arg * arg) >>> 16);
        u = sat32(65536 - sq);
        w = sat32((u * u) >>> 16);
        res.energy = 32'(sat32((e_scale * w) >>> 16));
        fo = '{0, 0, 0};
        if (r == 0) begin
            res.pair_status = pbf_pkg::ST_COINCIDENT;
        end else begin
            res.pair_status = pbf_pkg::ST_COMPUTED;
            pq = sat32((u * arg) >>> 16);
            q = sat32(4 * pq);
            g = sat32((q * 65536) / rad);
            s = sat32((g * e_scale) >>> 16);
            for (int i = 0; i < 3; i++) begin
                prod = t_wide'(s) * t_wide'(d[i]);
                fo[i] = sat32(prod / t_wide'(r));
            end
        end
        res.force_x = 32'(fo[0]);
        res.force_y = 32'(fo[1]);
        res.force_z = 32'(fo[2]);
        return res;
    endfunction

    // score each accepted pair
    always @(posedge i_clk) begin
        t_pair p;
        if (i_rst_n && pair_ch.valid && pair_ch.ready) begin
            p.ax = pair_ch.first_x;  p.ay = pair_ch.first_y;  p.az = pair_ch.first_z;
            p.bx = pair_ch.second_x; p.by = pair_ch.second_y; p.bz = pair_ch.second_z;
            p.ta = pair_ch.first_type; p.tb = pair_ch.second_type;
            expected_results.push_back(force_of_pair(p));
            n_pairs++;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        pbf_pkg::t_result exp_r;
        bit bad;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat at cycle %0d", cycles);
            end else begin
                exp_r = expected_results.pop_front();
                bad = exp_r.energy !== res_ch.energy || exp_r.force_x !== res_ch.force_x ||
                      exp_r.force_y !== res_ch.force_y || exp_r.force_z !== res_ch.force_z ||
                      exp_r.pair_status !== res_ch.pair_status;
                if (exp_r.pair_status == pbf_pkg::ST_INACTIVE) n_inactive++;
                if (exp_r.pair_status == pbf_pkg::ST_COINCIDENT) n_coincident++;
                if (bad) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch #%0d: exp e=%0d f=(%0d,%0d,%0d) st=%0d",
                                 n_results, exp_r.energy, exp_r.force_x, exp_r.force_y,
                                 exp_r.force_z, exp_r.pair_status);
                        $display("    got e=%0d f=(%0d,%0d,%0d) st=%0d",
                                 res_ch.energy, res_ch.force_x, res_ch.force_y,
                                 res_ch.force_z, res_ch.pair_status);
                    end
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_len > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else if (idling && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_pair(t_pair p);
        pair_ch.valid       <= 1'b1;
        pair_ch.first_x     <= p.ax;
        pair_ch.first_y     <= p.ay;
        pair_ch.first_z     <= p.az;
        pair_ch.second_x    <= p.bx;
        pair_ch.second_y    <= p.by;
        pair_ch.second_z    <= p.bz;
        pair_ch.first_type  <= p.ta;
        pair_ch.second_type <= p.tb;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        if (idling && $urandom_range(0, 3) == 0) begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        pair_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pbf_pkg::CFG_IDX_W-1:0] idx,
                             logic [pbf_pkg::CFG_W-1:0] val);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            pbf_pkg::CFG_WELL_OFFSET:  well_x0   = longint'(val);
            pbf_pkg::CFG_WELL_RADIUS:  well_rad  = longint'(val);
            pbf_pkg::CFG_ENERGY_SCALE: e_scale   = longint'(val);
            pbf_pkg::CFG_TYPE_MASK:    type_mask = val[15:0];
            pbf_pkg::CFG_FILTER_EN:    filt_on   = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pair random_pair();
        t_pair p;
        int sh;
        p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
        p.ta = 4'($urandom_range(0, 15));
        p.tb = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) begin
            p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
        end else begin
            // mostly short separations so r lands near the wells
            sh = $urandom_range(4, 31);
            p.bx = p.ax + ($signed($urandom) >>> sh);
            p.by = p.ay + ($signed($urandom) >>> sh);
            p.bz = p.az + ($signed($urandom) >>> sh);
            if ($urandom_range(0, 40) == 0) begin
                p.bx = p.ax; p.by = p.ay; p.bz = p.az;
            end
        end
        return p;
    endfunction

    function automatic t_pair make_pair(int ax, int ay, int az, int bx, int by, int bz,
                                        int ta, int tb);
        t_pair p;
        p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
        p.ta = 4'(ta); p.tb = 4'(tb);
        return p;
    endfunction

    task automatic set_well(longint x0, longint rad, longint sc, longint mask, longint filt);
        write_reg(pbf_pkg::CFG_WELL_OFFSET, pbf_pkg::CFG_W'(x0));
        write_reg(pbf_pkg::CFG_WELL_RADIUS, pbf_pkg::CFG_W'(rad));
        write_reg(pbf_pkg::CFG_ENERGY_SCALE, pbf_pkg::CFG_W'(sc));
        write_reg(pbf_pkg::CFG_TYPE_MASK, pbf_pkg::CFG_W'(mask));
        write_reg(pbf_pkg::CFG_FILTER_EN, pbf_pkg::CFG_W'(filt));
    endtask

    task automatic send_random(int n);
        repeat (n) send_pair(random_pair());
        end_burst();
    endtask

    task automatic test_directed();
        idling = 1'b0;
        send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h80000000, 0, 15));
        send_pair(make_pair(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 15, 0));
        send_pair(make_pair(5, 6, 7, 5, 6, 7, 3, 3));
        send_pair(make_pair(2 << 16, 0, 0, 0, 0, 0, 1, 2));
        send_pair(make_pair(0, 3 << 16, 0, 0, 0, 0, 1, 2));
        send_pair(make_pair(0, 0, 0, 0, 0, 1 << 16, 1, 2));
        send_pair(make_pair(1, 0, 0, 0, 0, 0, 1, 2));
        end_burst();
        // filtering on: pairs inside and outside the mask
        write_reg(pbf_pkg::CFG_TYPE_MASK, pbf_pkg::CFG_W'(16'h8005));
        write_reg(pbf_pkg::CFG_FILTER_EN, pbf_pkg::CFG_W'(1));
        send_pair(make_pair(2 << 16, 0, 0, 0, 0, 0, 0, 2));
        send_pair(make_pair(2 << 16, 0, 0, 0, 0, 0, 15, 15));
        send_pair(make_pair(2 << 16, 0, 0, 0, 0, 0, 0, 1));
        send_pair(make_pair(2 << 16, 0, 0, 0, 0, 0, 14, 15));
        send_pair(make_pair(9, 9, 9, 9, 9, 9, 2, 0));
        end_burst();
        // zero radius behaves as the smallest step, unused index is ignored
        write_reg(pbf_pkg::CFG_WELL_RADIUS, pbf_pkg::CFG_W'(0));
        write_reg(CFG_IDX_UNUSED, 31'h7fffffff);
        send_pair(make_pair(3, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(1 << 16, 1 << 16, 0, 0, 0, 0, 2, 2));
        send_pair(make_pair(7, 7, 7, 7, 7, 7, 0, 15));
        end_burst();
    endtask

    task automatic test_config_sweep();
        idling = 1'b1;
        set_well(65536, 65536, 65536, 16'hffff, 0);
        send_random(200);
        set_well(0, 1, 31'h7fffffff, 16'h5a5a, 1);
        send_random(200);
        set_well(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 16'hffff, 1);
        send_random(200);
        set_well(3 << 16, 1 << 15, 1 << 20, 16'h00ff, 0);
        send_random(200);
        set_well(0, 31'h7fffffff, 0, 16'h0000, 1);
        send_random(150);
        repeat (2) begin
            set_well($urandom_range(0, 1 << 22), $urandom_range(1, 1 << 22),
                     $urandom_range(0, 1 << 24), $urandom_range(0, 16'hffff),
                     $urandom_range(0, 1));
            send_random(125);
        end
    endtask

    task automatic test_backpressure();
        idling = 1'b0;
        set_well(1 << 16, 1 << 16, 1 << 18, 16'hf0f0, 0);
        hold_len = HOLD_CYCLES;
        send_random(200);
    endtask

    task automatic test_streaming();
        idling = 1'b0;
        set_well(2 << 16, 1 << 17, 1 << 16, 16'h3c3c, 1);
        send_random(250);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= pbf_pkg::CFG_WELL_OFFSET;
        i_cfg_data <= '0;
        pair_ch.valid <= 1'b0;
        pair_ch.first_x <= '0;  pair_ch.first_y <= '0;  pair_ch.first_z <= '0;
        pair_ch.second_x <= '0; pair_ch.second_y <= '0; pair_ch.second_z <= '0;
        pair_ch.first_type <= '0; pair_ch.second_type <= '0;
        well_x0 = 65536; well_rad = 65536; e_scale = 65536;
        type_mask = '0; filt_on = 1'b0;
        cycles = 0; hold_len = 0; idling = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_streaming();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d pairs, %0d results (%0d masked off, %0d coincident)",
                 n_pairs, n_results, n_inactive, n_coincident);
        $display("register sweeps incl. zero radius and full-scale wells, one long output stall");
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("** pair_bistable_force: PASSED **");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("** pair_bistable_force: FAILED **");
        end
        $finish;
    end
endmodule
